### hw/rtl/kda_pkg.sv
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants for the key debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

    localparam int CodeW  = 5;
    localparam int CountW = 16;
    localparam int AddrW  = 3;
    localparam int DataW  = 16;

    typedef logic [CodeW-1:0]  code_t;
    typedef logic [CountW-1:0] count_t;

    // Configuration register indexes
    typedef enum logic [AddrW-1:0] {
        REG_ALLOW_MULTI = 3'd0,
        REG_ALLOW_REPEAT = 3'd1,
        REG_TWO_SPEED   = 3'd2,
        REG_FIRST_DELAY = 3'd3,
        REG_LATER_DELAY = 3'd4
    } reg_idx_t;

    localparam count_t FirstDelayReset = 16'd50;
    localparam count_t LaterDelayReset = 16'd10;
    localparam count_t CountMax        = 16'hFFFF;

    typedef struct packed {
        logic   allow_multi_press;
        logic   allow_repeat;
        logic   two_speed_repeat;
        count_t first_delay;
        count_t later_delay;
    } cfg_t;

    typedef struct packed {
        code_t  last_code;
        count_t hold_count;
        logic   use_later_delay;
    } scan_state_t;

    // True when exactly one bit of the code is set
    function automatic logic single_key(input code_t v);
        return (v != '0) && ((v & (v - code_t'(1))) == '0);
    endfunction

endpackage

### hw/rtl/kda_scan_core.sv
// ----------------------------------------------------------------------------
// kda_scan_core
// Next-state and key code logic for one keypad scan.
// ----------------------------------------------------------------------------
module kda_scan_core (
    input  kda_pkg::cfg_t        cfg,
    input  kda_pkg::scan_state_t cur,
    input  kda_pkg::code_t       first_sample,
    input  kda_pkg::code_t       second_sample,
    output kda_pkg::scan_state_t nxt,
    output kda_pkg::code_t       key_code
);
    import kda_pkg::*;

    logic   one_key;
    logic   pass_code;
    count_t count_inc;
    count_t delay_sel;

    assign one_key   = single_key(first_sample);
    assign pass_code = cfg.allow_multi_press | one_key;
    assign count_inc = (cur.hold_count == CountMax) ? cur.hold_count
                                                   : cur.hold_count + count_t'(1);
    assign delay_sel = cur.use_later_delay ? cfg.later_delay : cfg.first_delay;

    always_comb begin
        nxt      = cur;
        key_code = '0;
        if (first_sample != second_sample) begin
            // bounce: drop the count
            nxt.hold_count = '0;
        end else if (first_sample == '0) begin
            // release
            nxt.last_code       = '0;
            nxt.hold_count      = '0;
            nxt.use_later_delay = 1'b0;
        end else if (cur.last_code != first_sample) begin
            nxt.last_code  = first_sample;
            nxt.hold_count = '0;
            if (pass_code) begin
                key_code = first_sample;
            end
        end else if (!pass_code || !cfg.allow_repeat) begin
            nxt.hold_count = '0;
        end else if (count_inc > delay_sel) begin
            nxt.hold_count = '0;
            if (cfg.two_speed_repeat) begin
                nxt.use_later_delay = 1'b1;
            end
            key_code = first_sample;
        end else begin
            nxt.hold_count = count_inc;
        end
    end

endmodule

### hw/rtl/key_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Keypad debounce with typematic auto-repeat, one scan per request.
// ----------------------------------------------------------------------------
// Each input request carries two key bitmaps read one debounce interval apart
// and yields exactly one output request holding the accepted key code (zero
// when there is no key event). The block takes one scan every clock cycle
// while the output side keeps up; a scan is captured in the input register
// when it is accepted and moves to the result register as the pipe advances,
// and its code is offered on the output from there until the output side is
// ready to take it. The rate is set by the debounce state (remembered
// code, hold count, delay selector), which is read and updated in the single
// cycle a scan moves from the input register to the result register. Both
// registers stall together when the output side holds off, and the input
// side keeps accepting as long as the input register frees up. Configuration
// writes take effect on the next edge and are meant to be made while no scan
// is in flight.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat #(
    parameter int NUM_KEYS = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // scan requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [4:0] first_sample, [9:5] second_sample
    // key code results
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // [4:0] key_code
    // configuration writes
    input  logic                     cfg_we,
    input  logic [kda_pkg::AddrW-1:0] cfg_addr,
    input  logic [kda_pkg::DataW-1:0] cfg_wdata
);
    import kda_pkg::*;

    // Only the low NUM_KEYS key bits take part (capped at the field width)
    localparam int    KeyBits = (NUM_KEYS < CodeW) ? NUM_KEYS : CodeW;
    localparam code_t KeyMask = code_t'((1 << KeyBits) - 1);

    cfg_t        cfg_reg;
    scan_state_t state_reg;
    scan_state_t state_next;

    logic  in_valid_reg;
    code_t first_reg;
    code_t second_reg;
    logic  out_valid_reg;
    code_t code_reg;
    code_t code_next;

    logic advance;
    logic take_in;

    // Advance the pipe when the result register is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, code_reg};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.allow_multi_press <= 1'b0;
            cfg_reg.allow_repeat      <= 1'b1;
            cfg_reg.two_speed_repeat  <= 1'b1;
            cfg_reg.first_delay       <= FirstDelayReset;
            cfg_reg.later_delay       <= LaterDelayReset;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ALLOW_MULTI:  cfg_reg.allow_multi_press <= cfg_wdata[0];
                REG_ALLOW_REPEAT: cfg_reg.allow_repeat      <= cfg_wdata[0];
                REG_TWO_SPEED:    cfg_reg.two_speed_repeat  <= cfg_wdata[0];
                REG_FIRST_DELAY:  cfg_reg.first_delay       <= cfg_wdata;
                REG_LATER_DELAY:  cfg_reg.later_delay       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: hold the masked samples of one scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            first_reg  <= s_tdata[4:0] & KeyMask;
            second_reg <= s_tdata[9:5] & KeyMask;
        end
    end

    kda_scan_core u_core (
        .cfg           (cfg_reg),
        .cur           (state_reg),
        .first_sample  (first_reg),
        .second_sample (second_reg),
        .nxt           (state_next),
        .key_code      (code_next)
    );

    // Debounce state and result register move together on each advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            code_reg <= code_next;
        end
    end

endmodule

### dv/key_debounce_autorepeat_checker.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_checker
// Watches the scan, key code and register write channels of the debouncer,
// predicts every key code and compares it in order against the block.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_checker #(
    parameter int NUM_KEYS = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [4:0] first_sample, [9:5] second_sample
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,   // [4:0] key_code
    input  logic                      cfg_we,
    input  logic [kda_pkg::AddrW-1:0] cfg_addr,
    input  logic [kda_pkg::DataW-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        pending,
    output int                        codes_checked,
    output int                        key_events
);
    import kda_pkg::*;

    localparam code_t KeyMask = code_t'((1 << NUM_KEYS) - 1);

    cfg_t        regs;
    scan_state_t keys;
    code_t       expected_codes[$];
    int          fails;
    int          checked;
    int          events;

    // One scan through the debounce and repeat rules; updates the key state.
    function automatic code_t debounce_scan(input code_t a, input code_t b);
        count_t limit;
        if (a != b) begin
            keys.hold_count = '0;
            return '0;
        end
        if (a == '0) begin
            keys.last_code       = '0;
            keys.hold_count      = '0;
            keys.use_later_delay = 1'b0;
            return '0;
        end
        if (keys.last_code != a) begin
            keys.hold_count = '0;
            keys.last_code  = a;
            return (regs.allow_multi_press || $countones(a) == 1) ? a : '0;
        end
        if (!regs.allow_multi_press && $countones(a) != 1) begin
            keys.hold_count = '0;
            return '0;
        end
        if (!regs.allow_repeat) begin
            keys.hold_count = '0;
            return '0;
        end
        if (keys.hold_count != CountMax)
            keys.hold_count = keys.hold_count + 1'b1;
        limit = keys.use_later_delay ? regs.later_delay : regs.first_delay;
        if (keys.hold_count > limit) begin
            keys.hold_count = '0;
            if (regs.two_speed_repeat)
                keys.use_later_delay = 1'b1;
            return a;
        end
        return '0;
    endfunction

    always @(posedge aclk) begin : watch
        code_t want;
        code_t got;
        if (!aresetn) begin
            regs.allow_multi_press = 1'b0;
            regs.allow_repeat      = 1'b1;
            regs.two_speed_repeat  = 1'b1;
            regs.first_delay       = FirstDelayReset;
            regs.later_delay       = LaterDelayReset;
            keys.last_code         = '0;
            keys.hold_count        = '0;
            keys.use_later_delay   = 1'b0;
            expected_codes.delete();
            fails   = 0;
            checked = 0;
            events  = 0;
        end else begin
            // compare before predicting so a result never meets its own scan
            if (m_tvalid && m_tready) begin
                got = m_tdata[CodeW-1:0];
                if (expected_codes.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: key code %0h arrived with no scan outstanding",
                                 got);
                end else begin
                    want = expected_codes.pop_front();
                    checked++;
                    if (want != '0)
                        events++;
                    if (got != want) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: key_code expected %0h, got %0h (result %0d)",
                                     want, got, checked);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_codes.push_back(debounce_scan(s_tdata[CodeW-1:0] & KeyMask,
                                                       s_tdata[2*CodeW-1:CodeW] & KeyMask));
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ALLOW_MULTI:  regs.allow_multi_press = cfg_wdata[0];
                    REG_ALLOW_REPEAT: regs.allow_repeat      = cfg_wdata[0];
                    REG_TWO_SPEED:    regs.two_speed_repeat  = cfg_wdata[0];
                    REG_FIRST_DELAY:  regs.first_delay       = cfg_wdata[CountW-1:0];
                    REG_LATER_DELAY:  regs.later_delay       = cfg_wdata[CountW-1:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= fails;
        pending       <= expected_codes.size();
        codes_checked <= checked;
        key_events    <= events;
    end

endmodule

### dv/key_debounce_autorepeat_test.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_test
// Drives scans and register writes into the debouncer and reports the verdict.
// ----------------------------------------------------------------------------
// A directed opener walks bounce, release, single and multi-key presses,
// repeats at the smallest delays, a held key with repeat off and key switches
// without a release. Six random phases follow, each under its own register
// setting, made mostly of held keys with bounce and release mixed in plus
// some pure noise. The checker beside the block predicts and compares every
// key code; this module only makes stimulus, handles back-pressure and prints
// the verdict.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_test;
    import kda_pkg::*;

    localparam int NumKeys      = 5;
    localparam int CycleLimit   = 1_000_000;
    localparam int PhaseScans   = 140;
    localparam int HoldOffLen   = 80;
    // first and last register index past the defined registers
    localparam logic [AddrW-1:0] RegPastEnd = REG_LATER_DELAY + 1'b1;
    localparam logic [AddrW-1:0] RegTopIdx  = {AddrW{1'b1}};

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;   // [4:0] first_sample, [9:5] second_sample
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;          // [4:0] key_code
    logic             cfg_we    = 1'b0;
    logic [AddrW-1:0] cfg_addr  = '0;
    logic [DataW-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int codes_checked;
    int key_events;

    int cycle_count   = 0;
    int scans_sent    = 0;
    int settings_used = 0;
    int hold_off_left = 0;
    bit no_idle       = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    key_debounce_autorepeat #(
        .NUM_KEYS (NumKeys)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    key_debounce_autorepeat_checker #(
        .NUM_KEYS (NumKeys)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .codes_checked (codes_checked),
        .key_events    (key_events)
    );

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: drop ready at random, or for a long counted hold-off when
    // the stimulus asks for one, so the block backs up into its input.
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Offer one scan request and hold it until accepted. Returns at the
    // falling edge after the handshake with valid still high, so back-to-back
    // requests drop valid in between only when the sender idles at random.
    task automatic send_scan(input code_t first_s, input code_t second_s);
        while (!no_idle && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'({second_s, first_s});
        do @(posedge aclk); while (!s_tready);
        scans_sent++;
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted key code has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        @(negedge aclk);
    endtask

    // Write one register; leaves the write enable high for the caller.
    task automatic write_reg(input logic [AddrW-1:0] idx, input logic [DataW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    // Program all registers while idle. Junk goes into the unused upper bits
    // of the flags and into the indexes past the list, neither of which may
    // change anything.
    task automatic load_config(input logic multi, input logic rpt, input logic two,
                               input count_t first_d, input count_t later_d);
        write_reg(REG_ALLOW_MULTI,  {(DataW-1)'($urandom), multi});
        write_reg(REG_ALLOW_REPEAT, {(DataW-1)'($urandom), rpt});
        write_reg(REG_TWO_SPEED,    {(DataW-1)'($urandom), two});
        write_reg(REG_FIRST_DELAY,  first_d);
        write_reg(REG_LATER_DELAY,  later_d);
        for (int i = RegPastEnd; i <= RegTopIdx; i++)
            write_reg(AddrW'(i), DataW'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    // A key held for a while with some bounce, then released or switched.
    task automatic press_run();
        code_t code;
        code_t other;
        int    len;
        if ($urandom_range(0, 3) == 0)
            code = code_t'($urandom_range(1, 31));
        else
            code = code_t'(1 << $urandom_range(0, CodeW - 1));
        len = $urandom_range(1, 20);
        repeat (len) begin
            if ($urandom_range(0, 99) < 8) begin
                other = code ^ code_t'($urandom_range(1, 31));
                if ($urandom_range(0, 1))
                    send_scan(code, other);
                else
                    send_scan(other, code);
            end else begin
                send_scan(code, code);
            end
        end
        // release about half the runs; the rest roll straight into a new key
        if ($urandom_range(0, 1))
            send_scan('0, '0);
    endtask

    initial begin : stimulus
        int phase_start;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: single key only, two-speed repeat at 50 then 10.
        send_scan('0, '0);                  // release from idle
        send_scan(5'h01, 5'h02);            // bounce
        send_scan(5'h10, 5'h10);            // new single key, reported
        send_scan(5'h10, 5'h10);            // held, counting
        send_scan(5'h1F, 5'h1F);            // new multi-key code, suppressed
        send_scan(5'h1F, 5'h1F);            // held multi-key code, suppressed
        send_scan(5'h1F, 5'h00);            // bounce against all keys
        send_scan('0, '0);
        settle();

        // Zero first delay: the first held scan repeats; switch keys without a
        // release so the later delay stays selected.
        load_config(1'b1, 1'b1, 1'b1, 16'd0, 16'd1);
        repeat (5) send_scan(5'h1F, 5'h1F);
        repeat (4) send_scan(5'h01, 5'h01);
        send_scan('0, '0);
        settle();

        // Repeat off: a held key only reports once.
        load_config(1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
        repeat (3) send_scan(5'h02, 5'h02);
        send_scan('0, '0);
        settle();

        // Random phases, one register setting each; the sender drains fully
        // between them.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_config(1'b0, 1'b1, 1'b1, 16'd3, 16'd1);
                1: load_config(1'b1, 1'b1, 1'b0, 16'd0, 16'd0);
                2: load_config(1'b1, 1'b1, 1'b1, 16'd6, 16'd2);
                3: load_config(1'b0, 1'b0, 1'b1, 16'd2, 16'd1);
                4: load_config(1'($urandom), ($urandom_range(0, 3) != 0), 1'($urandom),
                               count_t'($urandom_range(0, 10)),
                               count_t'($urandom_range(0, 5)));
                default: load_config(1'b1, 1'b1, 1'b1, 16'd2, 16'd65534);
            endcase
            // one phase runs without any idling on either side
            no_idle = (p == 1);
            // hold off the result side while scans keep coming
            if (p == 2)
                hold_off_left = HoldOffLen;
            phase_start = scans_sent;
            while (scans_sent - phase_start < PhaseScans) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4))
                        send_scan(code_t'($urandom), code_t'($urandom));
                end else begin
                    press_run();
                end
            end
            no_idle = 1'b0;
            settle();
        end

        // let any stray result show up
        repeat (8) @(posedge aclk);

        $display("Ran %0d scans under %0d register settings, with a long output stall.",
                 scans_sent, settings_used);
        $display("Compared %0d key codes, %0d of them presses or repeats.",
                 codes_checked, key_events);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/kda_pkg.sv
hw/rtl/kda_scan_core.sv
hw/rtl/key_debounce_autorepeat.sv
dv/key_debounce_autorepeat_checker.sv
dv/key_debounce_autorepeat_test.sv
